[src/srt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;

	localparam int DEPTH_DEF   = 32;
	localparam int MAX_RESULTS = 32;
	localparam int SLOT_W      = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [63:0]        name_head;
		logic [7:0]         name_tail;
		logic [7:0]         age;
		logic signed [31:0] id;
	} rec_t;

	typedef struct packed {
		logic [1:0]        status;
		rec_t              rec;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

[src/srt_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module srt_store #(
	parameter int DEPTH = srt_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  srt_pkg::rec_t    wdata,
	input  wire              re,
	input  wire [AW-1:0]     raddr,
	output srt_pkg::rec_t    rdata
);

	srt_pkg::rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/srt_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
module srt_outq (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  srt_pkg::res_t  push_data,
	input  wire            pop,
	output logic [1:0]     occ,
	output srt_pkg::res_t  head
);

	srt_pkg::res_t buf_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= occ_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	assign occ  = occ_q;
	assign head = buf_q[rd_ptr_q];

endmodule
`default_nettype wire

[src/sorted_record_table.sv]
// Insert: a downward walk that reads and shifts one entry a cycle, then the result word.
// Lookup: one entry compared a cycle through the record memory.
// Dump: one word a cycle while the two-word output queue that holds the words has room.
// One command is worked at a time; the next is taken once the result word is queued, or for
// a dump once the memory read of its last word is issued.
// Reset clears the fill count and control state at once; the record memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_record_table #(
	parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [1:0]        cmd,
	input  wire  [63:0]       key_name_head,
	input  wire  [7:0]        key_name_tail,
	input  wire  [7:0]        new_age,
	input  wire signed [31:0] new_id,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [1:0]        status,
	output logic [63:0]       out_name_head,
	output logic [7:0]        out_name_tail,
	output logic [7:0]        out_age,
	output logic signed [31:0] out_id,
	output logic [4:0]        slot,
	output logic              last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS  = 6'b000010,
		S_INS0 = 6'b000100,
		S_LKP  = 6'b001000,
		S_DMP  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [AW-1:0] dend_q, dend_d;
	srt_pkg::rec_t key_q, key_d;
	srt_pkg::res_t res_q, res_d;
	logic          infl_q, infl_d;
	logic [AW-1:0] infl_addr_q, infl_addr_d;
	logic          infl_last_q, infl_last_d;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	srt_pkg::rec_t mem_wdata, mem_rdata;

	logic          q_push, q_pop, room;
	srt_pkg::res_t q_data, q_head;
	logic [1:0]    q_occ;
	logic [2:0]    pending;
	logic          accept;
	srt_pkg::rec_t in_rec;

	srt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	srt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.occ       (q_occ),
		.head      (q_head)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_rec   = '{name_head: key_name_head, name_tail: key_name_tail,
	                    age: new_age, id: new_id};

	assign out_valid     = (q_occ != 2'd0);
	assign q_pop         = out_valid && !out_stall;
	assign status        = q_head.status;
	assign out_name_head = q_head.rec.name_head;
	assign out_name_tail = q_head.rec.name_tail;
	assign out_age       = q_head.rec.age;
	assign out_id        = q_head.rec.id;
	assign slot          = q_head.slot;
	assign last          = q_head.last;

	// A queue place counts as taken once its word is in the queue or still in the memory read.
	assign pending = {1'b0, q_occ} + {2'b00, infl_q} - {2'b00, q_pop};
	assign room    = (pending < 3'd2);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		addr_d      = addr_q;
		dend_d      = dend_q;
		key_d       = key_q;
		res_d       = res_q;
		infl_d      = 1'b0;
		infl_addr_d = infl_addr_q;
		infl_last_d = infl_last_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = key_q;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		q_push      = 1'b0;
		q_data      = res_q;

		// Dump words come out of the memory in the cycle after their read.
		if (infl_q) begin
			q_push = 1'b1;
			q_data = '{status: srt_pkg::ST_OK, rec: mem_rdata,
			           slot: srt_pkg::SLOT_W'(infl_addr_q), last: infl_last_q};
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_d = in_rec;
					res_d = '{status: srt_pkg::ST_EMPTY, rec: '0, slot: '0, last: 1'b1};
					case (cmd)
						srt_pkg::CMD_INSERT: begin
							if (fill_q == CW'(DEPTH)) begin
								res_d.status = srt_pkg::ST_FULL;
								state_d      = S_EMIT;
							end else if (fill_q == '0) begin
								mem_we    = 1'b1;
								mem_waddr = '0;
								mem_wdata = in_rec;
								fill_d    = fill_q + 1'b1;
								res_d     = '{status: srt_pkg::ST_OK, rec: in_rec,
								              slot: '0, last: 1'b1};
								state_d   = S_EMIT;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(fill_q - 1'b1);
								addr_d    = AW'(fill_q - 1'b1);
								state_d   = S_INS;
							end
						end
						srt_pkg::CMD_LOOKUP: begin
							if (fill_q == '0) begin
								state_d = S_EMIT;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								addr_d    = '0;
								state_d   = S_LKP;
							end
						end
						srt_pkg::CMD_DUMP: begin
							if (fill_q == '0) begin
								state_d = S_EMIT;
							end else begin
								addr_d = '0;
								if (int'(fill_q) > srt_pkg::MAX_RESULTS) begin
									dend_d = AW'(srt_pkg::MAX_RESULTS - 1);
								end else begin
									dend_d = AW'(fill_q - 1'b1);
								end
								state_d = S_DMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				// Entries at or above the new id move up by one while the walk goes down.
				mem_we = 1'b1;
				if (mem_rdata.id >= key_q.id) begin
					mem_waddr = AW'(addr_q + 1'b1);
					mem_wdata = mem_rdata;
					if (addr_q == '0) begin
						state_d = S_INS0;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = AW'(addr_q - 1'b1);
						addr_d    = AW'(addr_q - 1'b1);
					end
				end else begin
					mem_waddr = AW'(addr_q + 1'b1);
					mem_wdata = key_q;
					fill_d    = fill_q + 1'b1;
					res_d     = '{status: srt_pkg::ST_OK, rec: key_q,
					              slot: srt_pkg::SLOT_W'(AW'(addr_q + 1'b1)), last: 1'b1};
					state_d   = S_EMIT;
				end
			end
			S_INS0: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = key_q;
				fill_d    = fill_q + 1'b1;
				res_d     = '{status: srt_pkg::ST_OK, rec: key_q, slot: '0, last: 1'b1};
				state_d   = S_EMIT;
			end
			S_LKP: begin
				if (mem_rdata.name_head == key_q.name_head &&
				    mem_rdata.name_tail == key_q.name_tail) begin
					res_d   = '{status: srt_pkg::ST_OK, rec: mem_rdata,
					            slot: srt_pkg::SLOT_W'(addr_q), last: 1'b1};
					state_d = S_EMIT;
				end else if ({1'b0, addr_q} == (AW+1)'(fill_q - 1'b1)) begin
					res_d   = '{status: srt_pkg::ST_NOTFOUND, rec: '0, slot: '0, last: 1'b1};
					state_d = S_EMIT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(addr_q + 1'b1);
					addr_d    = AW'(addr_q + 1'b1);
				end
			end
			S_DMP: begin
				if (room) begin
					mem_re      = 1'b1;
					mem_raddr   = addr_q;
					infl_d      = 1'b1;
					infl_addr_d = addr_q;
					infl_last_d = (addr_q == dend_q);
					addr_d      = AW'(addr_q + 1'b1);
					if (addr_q == dend_q) begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (room) begin
					q_push  = 1'b1;
					q_data  = res_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			infl_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			infl_q  <= infl_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q      <= addr_d;
		dend_q      <= dend_d;
		key_q       <= key_d;
		res_q       <= res_d;
		infl_addr_q <= infl_addr_d;
		infl_last_q <= infl_last_d;
	end

endmodule
`default_nettype wire
